### rtl/life_pkg.sv
package life_pkg;

  localparam int CMD_W       = 3;
  localparam int COORD_W     = 6;
  localparam int GRID_SIDE_W = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [COORD_W-1:0] coord_t;

  localparam cmd_t CMD_WRITE  = 3'd0;
  localparam cmd_t CMD_TOGGLE = 3'd1;
  localparam cmd_t CMD_READ   = 3'd2;
  localparam cmd_t CMD_STEP   = 3'd3;
  localparam cmd_t CMD_CLEAR  = 3'd4;
  localparam cmd_t CMD_FILL   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_MODE = 1'd1;

  localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RESET = 7'd64;
  localparam logic [GRID_SIDE_W-1:0] SIDE_MIN        = 7'd3;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

### rtl/life_if.sv
interface life_req_if import life_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   command;
  coord_t row;
  coord_t col;
  logic   value;

  modport source (output valid, output command, output row, output col, output value,
                  input ready);
  modport sink (input valid, input command, input row, input col, input value,
                output ready);
endinterface

interface life_rsp_if import life_pkg::*; ();
  logic valid;
  logic ready;
  logic cell_value;
  logic in_range;

  modport source (output valid, output cell_value, output in_range, input ready);
  modport sink (input valid, input cell_value, input in_range, output ready);
endinterface

### rtl/life_cellular_automaton_step.sv
// channel   direction  handshake      payload
// req       in         valid/ready    command, row, col, value
// rsp       out        valid/ready    cell_value, in_range
// cfg       in         cfg_we         cfg_index, cfg_data
//
// one request at a time; the grid lives in one row-wide memory holding both buffers
// cell commands read and write one row (none when out of range or unused), clear and fill
// rewrite each row below side, a step computes each row below side and then copies the rows beyond side
// after reset a clearing pass over the whole memory runs before req.ready rises
// the next request is taken while a response still waits in the output register
module life_cellular_automaton_step import life_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  life_req_if.sink              req,
  life_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W  = $clog2(MAX_SIDE);
  localparam int ADDR_W = ROW_W + 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > GRID_SIDE_W) ? SIDE_W : GRID_SIDE_W;
  localparam int FET_W  = CMP_W + 1;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CELL_RD  = 4'd2;
  localparam logic [3:0] S_CELL_WR  = 4'd3;
  localparam logic [3:0] S_FL_RD    = 4'd4;
  localparam logic [3:0] S_FL_WR    = 4'd5;
  localparam logic [3:0] S_ST_FETCH = 4'd6;
  localparam logic [3:0] S_ST_PUSH  = 4'd7;
  localparam logic [3:0] S_ST_CALC  = 4'd8;
  localparam logic [3:0] S_CP_RD    = 4'd9;
  localparam logic [3:0] S_CP_WR    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]             state;
  logic                   act;
  logic [GRID_SIDE_W-1:0] grid_side;
  logic                   boundary_mode;
  logic [ADDR_W-1:0]      clr_addr;
  cmd_t                   cmd_q;
  logic [ROW_W-1:0]       row_q;
  logic [ROW_W-1:0]       col_q;
  logic                   val_q;
  logic [ROW_W-1:0]       r;
  logic [FET_W-1:0]       f;
  logic                   push_zero;
  logic [MAX_SIDE-1:0]    win_up;
  logic [MAX_SIDE-1:0]    win_mid;
  logic [MAX_SIDE-1:0]    win_dn;
  logic                   res_cell;
  logic                   res_ok;
  logic                   rsp_valid;
  logic                   rsp_cell;
  logic                   rsp_ok;

  logic [MAX_SIDE-1:0]    mem [2**ADDR_W];
  logic [MAX_SIDE-1:0]    rd_data;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [MAX_SIDE-1:0]    wr_data;

  logic [CMP_W-1:0]       gs;
  logic [CMP_W-1:0]       side;
  logic [ROW_W-1:0]       side_m1;
  logic                   req_in_range;
  logic                   fetch_zero;
  logic [ROW_W-1:0]       fetch_row;
  logic                   cell_new;
  logic [MAX_SIDE-1:0]    cell_row;
  logic [MAX_SIDE-1:0]    fill_row;
  logic [MAX_SIDE-1:0]    step_row;
  logic                   load_rsp;

  // side in use, clamped
  assign gs      = CMP_W'(grid_side);
  assign side    = (gs < CMP_W'(SIDE_MIN)) ? CMP_W'(SIDE_MIN) :
                   ((gs > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE) : gs);
  assign side_m1 = ROW_W'(side - CMP_W'(1));

  assign req_in_range = (CMP_W'(req.row) < side) && (CMP_W'(req.col) < side);

  // logical row f-1 of the step window, with the rows beyond the edges
  always_comb begin
    fetch_zero = 1'b0;
    fetch_row  = ROW_W'(f - FET_W'(1));
    if (f == '0) begin
      fetch_zero = !boundary_mode;
      fetch_row  = side_m1;
    end else if (f == FET_W'(side) + FET_W'(1)) begin
      fetch_zero = !boundary_mode;
      fetch_row  = '0;
    end
  end

  always_comb begin
    case (cmd_q)
      CMD_WRITE:  cell_new = val_q;
      CMD_TOGGLE: cell_new = !rd_data[col_q];
      default:    cell_new = rd_data[col_q];
    endcase
    cell_row        = rd_data;
    cell_row[col_q] = cell_new;
  end

  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      fill_row[c] = (CMP_W'(c) < side) ? (cmd_q == CMD_FILL) : rd_data[c];
    end
  end

  // next generation of the middle row of the window
  always_comb begin
    logic [MAX_SIDE+1:0] up_ext;
    logic [MAX_SIDE+1:0] mid_ext;
    logic [MAX_SIDE+1:0] dn_ext;
    logic                rt_up;
    logic                rt_mid;
    logic                rt_dn;
    logic                last_col;
    logic [3:0]          n;
    up_ext  = {1'b0, win_up, boundary_mode & win_up[side_m1]};
    mid_ext = {1'b0, win_mid, boundary_mode & win_mid[side_m1]};
    dn_ext  = {1'b0, win_dn, boundary_mode & win_dn[side_m1]};
    for (int c = 0; c < MAX_SIDE; c++) begin
      last_col = (ROW_W'(c) == side_m1);
      rt_up    = last_col ? (boundary_mode & win_up[0]) : up_ext[c+2];
      rt_mid   = last_col ? (boundary_mode & win_mid[0]) : mid_ext[c+2];
      rt_dn    = last_col ? (boundary_mode & win_dn[0]) : dn_ext[c+2];
      n = 4'(up_ext[c]) + 4'(up_ext[c+1]) + 4'(rt_up) + 4'(mid_ext[c]) + 4'(rt_mid)
        + 4'(dn_ext[c]) + 4'(dn_ext[c+1]) + 4'(rt_dn);
      step_row[c] = (CMP_W'(c) < side) ?
                    ((n == BIRTH_COUNT) || (win_mid[c] && (n == SURVIVE_COUNT))) :
                    win_mid[c];
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {act, r};
    wr_en   = 1'b0;
    wr_addr = {!act, r};
    wr_data = rd_data;
    unique case (state)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_CELL_RD: begin
        rd_en   = 1'b1;
        rd_addr = {act, row_q};
      end
      S_CELL_WR: begin
        wr_en   = 1'b1;
        wr_addr = {act, row_q};
        wr_data = cell_row;
      end
      S_FL_RD: begin
        rd_en = 1'b1;
      end
      S_FL_WR: begin
        wr_en   = 1'b1;
        wr_addr = {act, r};
        wr_data = fill_row;
      end
      S_ST_FETCH: begin
        rd_en   = !fetch_zero;
        rd_addr = {act, fetch_row};
      end
      S_ST_CALC: begin
        wr_en   = 1'b1;
        wr_data = step_row;
      end
      S_CP_RD: begin
        rd_en = 1'b1;
      end
      S_CP_WR: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side     <= GRID_SIDE_RESET;
      boundary_mode <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_SIDE) begin
        grid_side <= cfg_data[GRID_SIDE_W-1:0];
      end else if (cfg_index == CFG_BOUNDARY_MODE) begin
        boundary_mode <= cfg_data[0];
      end
    end
  end

  assign load_rsp = (state == S_DONE) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      act      <= 1'b0;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cmd_q <= req.command;
            row_q <= ROW_W'(req.row);
            col_q <= ROW_W'(req.col);
            val_q <= req.value;
            r     <= '0;
            f     <= '0;
            unique case (req.command) inside
              CMD_WRITE, CMD_TOGGLE, CMD_READ: begin
                if (req_in_range) begin
                  state <= S_CELL_RD;
                end else begin
                  res_cell <= 1'b0;
                  res_ok   <= 1'b0;
                  state    <= S_DONE;
                end
              end
              CMD_STEP: begin
                state <= S_ST_FETCH;
              end
              CMD_CLEAR, CMD_FILL: begin
                state <= S_FL_RD;
              end
              default: begin
                res_cell <= 1'b0;
                res_ok   <= 1'b0;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_CELL_RD: begin
          state <= S_CELL_WR;
        end
        S_CELL_WR: begin
          res_cell <= cell_new;
          res_ok   <= 1'b1;
          state    <= S_DONE;
        end
        S_FL_RD: begin
          state <= S_FL_WR;
        end
        S_FL_WR: begin
          if (r == side_m1) begin
            res_cell <= 1'b0;
            res_ok   <= 1'b1;
            state    <= S_DONE;
          end else begin
            r     <= r + ROW_W'(1);
            state <= S_FL_RD;
          end
        end
        S_ST_FETCH: begin
          push_zero <= fetch_zero;
          state     <= S_ST_PUSH;
        end
        S_ST_PUSH: begin
          win_up  <= win_mid;
          win_mid <= win_dn;
          win_dn  <= push_zero ? '0 : rd_data;
          f       <= f + FET_W'(1);
          state   <= (f < FET_W'(2)) ? S_ST_FETCH : S_ST_CALC;
        end
        S_ST_CALC: begin
          if (r == side_m1) begin
            if (side == CMP_W'(MAX_SIDE)) begin
              act      <= !act;
              res_cell <= 1'b0;
              res_ok   <= 1'b1;
              state    <= S_DONE;
            end else begin
              r     <= ROW_W'(side);
              state <= S_CP_RD;
            end
          end else begin
            r     <= r + ROW_W'(1);
            state <= S_ST_FETCH;
          end
        end
        S_CP_RD: begin
          state <= S_CP_WR;
        end
        S_CP_WR: begin
          if (r == ROW_W'(MAX_SIDE - 1)) begin
            act      <= !act;
            res_cell <= 1'b0;
            res_ok   <= 1'b1;
            state    <= S_DONE;
          end else begin
            r     <= r + ROW_W'(1);
            state <= S_CP_RD;
          end
        end
        S_DONE: begin
          if (load_rsp) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_cell <= res_cell;
      rsp_ok   <= res_ok;
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.cell_value = rsp_cell;
  assign rsp.in_range   = rsp_ok;

  // reads only ever see the buffer in use
  assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (rd_addr[ADDR_W-1] == act))
    else $error("read from inactive buffer");

  // buffers swap only at the end of a step
  assert property (@(posedge clk) disable iff (rst)
    (act != $past(act)) |-> (($past(state) == S_ST_CALC) || ($past(state) == S_CP_WR)))
    else $error("buffer swap outside a step");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.in_range || !rsp.cell_value))
    else $error("cell value set on a rejected request");

  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("request accepted without work");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import life_pkg::*;

  localparam int MAX_SIDE = 64;
  localparam int CYCLE_LIMIT = 600000;

  localparam cmd_t CMD_SPARE_6 = 3'd6;
  localparam cmd_t CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic cell_value;
    logic in_range;
  } life_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  life_req_if req_if ();
  life_rsp_if rsp_if ();

  life_cellular_automaton_step #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted block state
  bit [MAX_SIDE-1:0] life_grid [2][MAX_SIDE];
  bit life_active;
  logic [GRID_SIDE_W-1:0] side_reg;
  logic wrap_reg;

  life_result_t expected_results[$];
  int error_count;
  int requests_sent;
  int responses_checked;
  int generations;
  int cycle_count;
  int stall_left;
  bit quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (quiet) return 0;
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned side_now();
    if (side_reg < SIDE_MIN) return 32'(SIDE_MIN);
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return 32'(side_reg);
  endfunction

  function automatic int unsigned live_neighbours(int r, int c, int s);
    int cnt;
    int nr;
    int nc;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        nr = r + dr;
        nc = c + dc;
        if (wrap_reg) begin
          nr = (nr + s) % s;
          nc = (nc + s) % s;
        end else if (nr < 0 || nc < 0 || nr >= s || nc >= s) begin
          continue;
        end
        cnt += 32'(life_grid[life_active][nr][nc]);
      end
    end
    return cnt;
  endfunction

  function automatic void advance_generation();
    int s;
    int unsigned n;
    bit nb;
    s = side_now();
    nb = ~life_active;
    for (int r = 0; r < MAX_SIDE; r++) life_grid[nb][r] = life_grid[life_active][r];
    for (int r = 0; r < s; r++) begin
      for (int c = 0; c < s; c++) begin
        n = live_neighbours(r, c, s);
        if (life_grid[life_active][r][c]) life_grid[nb][r][c] = (n == 2 || n == 3);
        else life_grid[nb][r][c] = (n == 3);
      end
    end
    life_active = nb;
  endfunction

  function automatic void paint_grid(bit v);
    int s;
    s = side_now();
    for (int r = 0; r < s; r++)
      for (int c = 0; c < s; c++) life_grid[life_active][r][c] = v;
  endfunction

  function automatic life_result_t apply_command(cmd_t c, coord_t r, coord_t cl, logic v);
    life_result_t res;
    int s;
    s = side_now();
    res = '0;
    case (c)
      CMD_WRITE, CMD_TOGGLE, CMD_READ: begin
        if (r < s && cl < s) begin
          if (c == CMD_WRITE) life_grid[life_active][r][cl] = v;
          else if (c == CMD_TOGGLE) life_grid[life_active][r][cl] = ~life_grid[life_active][r][cl];
          res.cell_value = life_grid[life_active][r][cl];
          res.in_range = 1'b1;
        end
      end
      CMD_STEP: begin
        advance_generation();
        res.in_range = 1'b1;
      end
      CMD_CLEAR: begin
        paint_grid(1'b0);
        res.in_range = 1'b1;
      end
      CMD_FILL: begin
        paint_grid(1'b1);
        res.in_range = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_response(logic cv, logic ir);
    life_result_t want;
    if (expected_results.size() == 0) begin
      $error("response with nothing expected: cell_value %0b in_range %0b", cv, ir);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      responses_checked++;
      if (cv !== want.cell_value) begin
        $error("cell_value mismatch: expected %0b actual %0b", want.cell_value, cv);
        error_count++;
      end
      if (ir !== want.in_range) begin
        $error("in_range mismatch: expected %0b actual %0b", want.in_range, ir);
        error_count++;
      end
    end
  endtask

  // response side with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_response(rsp_if.cell_value, rsp_if.in_range);
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  task automatic issue_request(cmd_t c, coord_t r, coord_t cl, logic v);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= c;
    req_if.row <= r;
    req_if.col <= cl;
    req_if.value <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_results.push_back(apply_command(c, r, cl, v));
    requests_sent++;
    if (c == CMD_STEP) generations++;
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_responses();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_SIDE) side_reg = data;
    else wrap_reg = data[0];
    @(posedge clk);
  endtask

  task automatic test_cell_commands();
    issue_request(CMD_READ, 6'd0, 6'd0, 1'b0);
    issue_request(CMD_READ, 6'd63, 6'd63, 1'b1);
    issue_request(CMD_WRITE, 6'd63, 6'd63, 1'b1);
    issue_request(CMD_WRITE, 6'd0, 6'd0, 1'b1);
    issue_request(CMD_TOGGLE, 6'd0, 6'd63, 1'b0);
    issue_request(CMD_TOGGLE, 6'd0, 6'd63, 1'b1);
    issue_request(CMD_WRITE, 6'd0, 6'd0, 1'b0);
    issue_request(CMD_SPARE_6, 6'd63, 6'd63, 1'b1);
    issue_request(CMD_SPARE_7, 6'd42, 6'd21, 1'b0);
    // blinker away from the border
    issue_request(CMD_WRITE, 6'd10, 6'd9, 1'b1);
    issue_request(CMD_WRITE, 6'd10, 6'd10, 1'b1);
    issue_request(CMD_WRITE, 6'd10, 6'd11, 1'b1);
    issue_request(CMD_STEP, 6'd0, 6'd0, 1'b0);
    issue_request(CMD_READ, 6'd9, 6'd10, 1'b0);
    issue_request(CMD_READ, 6'd10, 6'd9, 1'b0);
    issue_request(CMD_FILL, 6'd0, 6'd0, 1'b0);
    issue_request(CMD_READ, 6'd32, 6'd32, 1'b0);
  endtask

  task automatic test_config_extremes();
    // shrink the side over a full grid, cells beyond it must survive
    write_reg(CFG_GRID_SIDE, 7'd5);
    write_reg(CFG_BOUNDARY_MODE, 7'd1);
    issue_request(CMD_CLEAR, 6'd0, 6'd0, 1'b0);
    issue_request(CMD_READ, 6'd5, 6'd0, 1'b0);
    issue_request(CMD_WRITE, 6'd0, 6'd4, 1'b1);
    write_reg(CFG_GRID_SIDE, 7'd0);
    issue_request(CMD_READ, 6'd3, 6'd2, 1'b0);
    issue_request(CMD_STEP, 6'd0, 6'd0, 1'b0);
    write_reg(CFG_GRID_SIDE, 7'd127);
    write_reg(CFG_BOUNDARY_MODE, 7'd0);
    issue_request(CMD_READ, 6'd10, 6'd10, 1'b0);
    issue_request(CMD_CLEAR, 6'd0, 6'd0, 1'b0);
  endtask

  task automatic test_random_generations();
    int sides [9] = '{4, 3, 7, 0, 5, 64, 8, 127, 6};
    bit wraps [9] = '{1, 0, 1, 1, 0, 1, 0, 0, 1};
    int n;
    int unsigned s;
    int unsigned p;
    cmd_t c;
    coord_t r;
    coord_t cl;
    logic v;
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_GRID_SIDE, sides[ph][GRID_SIDE_W-1:0]);
      write_reg(CFG_BOUNDARY_MODE, CFG_DATA_W'(wraps[ph]));
      quiet = (ph == 2);
      s = side_now();
      n = (s == MAX_SIDE) ? 6 : 16;
      for (int i = 0; i < n; i++) begin
        if (ph == 4 && i == 8) drain_responses();
        p = $urandom_range(0, 99);
        if (p < 30) c = CMD_WRITE;
        else if (p < 42) c = CMD_TOGGLE;
        else if (p < 72) c = CMD_READ;
        else if (p < 88) c = CMD_STEP;
        else if (p < 92) c = CMD_CLEAR;
        else if (p < 96) c = CMD_FILL;
        else if (p < 98) c = CMD_SPARE_6;
        else c = CMD_SPARE_7;
        if ($urandom_range(0, 9) == 0) begin
          r = coord_t'($urandom_range(0, 63));
          cl = coord_t'($urandom_range(0, 63));
        end else begin
          r = coord_t'($urandom_range(0, s - 1));
          cl = coord_t'($urandom_range(0, s - 1));
        end
        v = ($urandom_range(0, 9) < 6);
        issue_request(c, r, cl, v);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.command = CMD_READ;
    req_if.row = '0;
    req_if.col = '0;
    req_if.value = 1'b0;
    error_count = 0;
    requests_sent = 0;
    responses_checked = 0;
    generations = 0;
    quiet = 1'b0;
    for (int g = 0; g < 2; g++)
      for (int r = 0; r < MAX_SIDE; r++) life_grid[g][r] = '0;
    life_active = 1'b0;
    side_reg = GRID_SIDE_RESET;
    wrap_reg = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_cell_commands();
    test_config_extremes();
    test_random_generations();

    drain_responses();
    repeat (20) @(posedge clk);
    $display("sent %0d requests including %0d generation steps, checked %0d responses",
             requests_sent, generations, responses_checked);
    $display("grid sides from 3 to 64 with dead and wrapped borders, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
